// ----- rtl/core/rnra_pkg.sv -----
// Shared types, codes and constants for the ring neighbor resource arbiter.
package rnra_pkg;

  localparam int DEFAULT_MAX_SEATS = 32;
  localparam int QUEUE_DEPTH       = 2;
  localparam int WHO_W             = 5;
  localparam int RING_W            = 6;
  localparam int USES_W            = 16;
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_DATA_W        = 16;

  typedef enum logic {
    OP_PICKUP  = 1'b0,
    OP_PUTDOWN = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_GRANTED  = 2'd0,
    KIND_WAITING  = 2'd1,
    KIND_RELEASED = 2'd2,
    KIND_FINISHED = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_SIZE  = 1'b0,
    CFG_TOTAL_USES = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    BK_RUN    = 1'b0,
    BK_SECOND = 1'b1
  } back_state_t;

  // Classified item as it waits between front and back.
  typedef struct packed {
    op_t              op;
    logic             out_of_ring;
    logic [WHO_W-1:0] who;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic             done;
    kind_t            kind;
    logic [WHO_W-1:0] target;
    logic             last;
  } res_t;

endpackage

// ----- rtl/core/rnra_front.sv -----
// Front end: takes command items and tags those outside the active ring.
module rnra_front #(
  parameter int MAX_SEATS = rnra_pkg::DEFAULT_MAX_SEATS
) (
  input  logic                                 start,
  input  rnra_pkg::op_t                        op,
  input  logic [rnra_pkg::WHO_W-1:0]           who,
  input  logic [$clog2(MAX_SEATS+1)-1:0]       n,
  input  logic                                 full,
  output logic                                 busy,
  output logic                                 push,
  output rnra_pkg::item_t                      push_item
);
  import rnra_pkg::*;

  localparam int NW = $clog2(MAX_SEATS + 1);
  localparam int WW = (NW > WHO_W) ? NW : WHO_W;

  assign busy = full;
  assign push = start && !full;

  always_comb begin
    push_item.op          = op;
    push_item.who         = who;
    push_item.out_of_ring = (WW'(who) >= WW'(n));
  end

endmodule

// ----- rtl/core/rnra_queue.sv -----
// Small item queue decoupling the front end from the executing back end.
module rnra_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rnra_pkg::item_t     push_item,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output rnra_pkg::item_t     head
);
  import rnra_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  item_t           entries [QUEUE_DEPTH];
  logic [QW-1:0]   wr_ptr;
  logic [QW-1:0]   rd_ptr;
  logic [QW:0]     count;

  assign full       = (count == (QW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  function automatic logic [QW-1:0] bump(input logic [QW-1:0] p);
    return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue pushed while full");

endmodule

// ----- rtl/core/rnra_back.sv -----
// Back end: seat flags, use counter and the result sequencer.
module rnra_back #(
  parameter int MAX_SEATS = rnra_pkg::DEFAULT_MAX_SEATS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               head_valid,
  input  rnra_pkg::item_t                    head,
  output logic                               pop,
  input  logic [$clog2(MAX_SEATS+1)-1:0]     n,
  input  logic [rnra_pkg::USES_W-1:0]        total_uses,
  output rnra_pkg::res_t                     res
);
  import rnra_pkg::*;

  localparam int NW = $clog2(MAX_SEATS + 1);
  localparam int SW = $clog2(MAX_SEATS);

  back_state_t         state, state_next;
  logic [MAX_SEATS-1:0] eating, eating_next;
  logic [MAX_SEATS-1:0] hungry, hungry_next;
  logic [USES_W-1:0]   use_count, use_count_next;
  logic                finished, finished_next;
  logic [SW-1:0]       second_tgt, second_tgt_next;
  res_t                res_next;

  logic [SW-1:0]       w, lft, rgt, ll, rr;
  logic [USES_W-1:0]   cnt_inc;
  logic                fin_hit, pick_ok, gl, gr, ll_eat, rr_eat;

  function automatic logic [SW-1:0] left_of(input logic [SW-1:0] s,
                                            input logic [NW-1:0] len);
    return (s == '0) ? SW'(len - 1'b1) : s - 1'b1;
  endfunction

  function automatic logic [SW-1:0] right_of(input logic [SW-1:0] s,
                                             input logic [NW-1:0] len);
    logic [SW:0] inc;
    inc = {1'b0, s} + 1'b1;
    return (inc >= (SW+1)'(len)) ? '0 : SW'(inc);
  endfunction

  // Neighbor tests; the releasing seat counts as thinking.
  always_comb begin
    w       = SW'(head.who);
    lft     = left_of(w, n);
    rgt     = right_of(w, n);
    ll      = left_of(lft, n);
    rr      = right_of(rgt, n);
    cnt_inc = (use_count == '1) ? use_count : use_count + 1'b1;
    fin_hit = (cnt_inc >= total_uses);
    pick_ok = !eating[lft] && !eating[rgt];
    ll_eat  = eating[ll] && (ll != w);
    gl      = hungry[lft] && !ll_eat;
    rr_eat  = (eating[rr] && (rr != w)) || (gl && (rr == lft));
    gr      = hungry[rgt] && !(gl && (rgt == lft)) && !rr_eat;
  end

  always_comb begin
    state_next      = state;
    eating_next     = eating;
    hungry_next     = hungry;
    use_count_next  = use_count;
    finished_next   = finished;
    second_tgt_next = second_tgt;
    pop             = 1'b0;
    res_next        = '{done: 1'b0, kind: KIND_GRANTED, target: head.who, last: 1'b1};
    unique case (state)
      BK_RUN: begin
        if (head_valid) begin
          pop = 1'b1;
          priority if (finished) begin
            res_next.done = 1'b1;
            res_next.kind = KIND_FINISHED;
          end else if (head.out_of_ring) begin
            res_next.done = 1'b0;
          end else if (head.op == OP_PICKUP) begin
            eating_next[w] = pick_ok;
            hungry_next[w] = !pick_ok;
            res_next.done  = 1'b1;
            res_next.kind  = pick_ok ? KIND_GRANTED : KIND_WAITING;
          end else begin
            eating_next[w] = 1'b0;
            hungry_next[w] = 1'b0;
            use_count_next = cnt_inc;
            res_next.done  = 1'b1;
            if (fin_hit) begin
              finished_next = 1'b1;
              res_next.kind = KIND_FINISHED;
            end else begin
              if (gl) begin
                eating_next[lft] = 1'b1;
                hungry_next[lft] = 1'b0;
              end
              if (gr) begin
                eating_next[rgt] = 1'b1;
                hungry_next[rgt] = 1'b0;
              end
              priority if (gl) begin
                res_next.kind   = KIND_GRANTED;
                res_next.target = WHO_W'(lft);
                res_next.last   = !gr;
                second_tgt_next = rgt;
                if (gr) begin
                  state_next = BK_SECOND;
                end
              end else if (gr) begin
                res_next.kind   = KIND_GRANTED;
                res_next.target = WHO_W'(rgt);
              end else begin
                res_next.kind = KIND_RELEASED;
              end
            end
          end
        end
      end
      BK_SECOND: begin
        res_next.done   = 1'b1;
        res_next.kind   = KIND_GRANTED;
        res_next.target = WHO_W'(second_tgt);
        state_next      = BK_RUN;
      end
      default: begin
        state_next = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_RUN;
      eating    <= '0;
      hungry    <= '0;
      use_count <= '0;
      finished  <= 1'b0;
      res       <= '0;
    end else begin
      state     <= state_next;
      eating    <= eating_next;
      hungry    <= hungry_next;
      use_count <= use_count_next;
      finished  <= finished_next;
      res       <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    second_tgt <= second_tgt_next;
  end

  a_second_follows_first: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SECOND) |-> (res.done && !res.last && res.kind == KIND_GRANTED))
    else $error("second grant without a first grant beat");

  a_finished_sticky: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("finished flag dropped");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (use_count >= $past(use_count)))
    else $error("use count went backwards");

  a_no_eat_and_hungry: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> ((eating & hungry) == '0))
    else $error("seat both eating and hungry");

endmodule

// ----- rtl/core/ring_neighbor_resource_arbiter.sv -----
// Ring neighbor resource arbiter (dining philosophers monitor): top level.
//
// Items (op, who) are taken when start is high and busy is low; busy rises
// only when the two-entry item queue between front and back is full. The
// back end executes one item per cycle, but takes none while it gives a
// second grant: a pickup gives one granted or waiting result, a putdown
// one released, finished or granted result, and a putdown that frees both
// neighbors gives its second grant from the second-grant state of the
// result sequencer. Results come out registered, one per cycle, with done
// high for exactly that cycle and last high on an item's final result; the
// receiver cannot stall, so nothing is held back. An item whose who is not
// inside the active ring gives no result, unless the block has finished, in
// which case every item gets a finished result. Seat states reset to
// thinking at once; no clearing pass. Configuration writes are always taken
// (cfg_ready stays high) and belong only in idle periods.
module ring_neighbor_resource_arbiter #(
  parameter int MAX_SEATS = rnra_pkg::DEFAULT_MAX_SEATS
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                op,
  input  logic [rnra_pkg::WHO_W-1:0]          who,
  // result strobe and payload
  output logic                                done,
  output logic [1:0]                          kind,
  output logic [rnra_pkg::WHO_W-1:0]          target,
  output logic                                last,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rnra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rnra_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rnra_pkg::*;

  localparam int NW = $clog2(MAX_SEATS + 1);
  localparam int CW = (NW > RING_W) ? NW : RING_W;

  logic [RING_W-1:0] ring_size;
  logic [USES_W-1:0] total_uses;
  logic [NW-1:0]     n;
  logic [CW-1:0]     rs_ext;

  logic  q_full, q_push, q_pop, q_head_valid;
  item_t q_push_item, q_head;
  res_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size  <= RING_W'(5);
      total_uses <= USES_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RING_SIZE:  ring_size  <= cfg_data[RING_W-1:0];
        CFG_TOTAL_USES: total_uses <= cfg_data[USES_W-1:0];
      endcase
    end
  end

  // Ring length in use: ring_size clamped to 2..MAX_SEATS.
  always_comb begin
    rs_ext = CW'(ring_size);
    priority if (rs_ext < CW'(2)) begin
      n = NW'(2);
    end else if (rs_ext > CW'(MAX_SEATS)) begin
      n = NW'(MAX_SEATS);
    end else begin
      n = NW'(rs_ext);
    end
  end

  rnra_front #(.MAX_SEATS(MAX_SEATS)) u_front (
    .start     (start),
    .op        (op_t'(op)),
    .who       (who),
    .n         (n),
    .full      (q_full),
    .busy      (busy),
    .push      (q_push),
    .push_item (q_push_item)
  );

  rnra_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  rnra_back #(.MAX_SEATS(MAX_SEATS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .n          (n),
    .total_uses (total_uses),
    .res        (res)
  );

  assign done   = res.done;
  assign kind   = res.kind;
  assign target = res.target;
  assign last   = res.last;

endmodule
